// ===== rtl/typed_numeric_string_checker_macros.svh =====
// ---------------------------------------------------------------------------
// typed_numeric_string_checker assertion macros
// Immediate-implication and next-cycle-implication property wrappers.
// ---------------------------------------------------------------------------
`ifndef TYPED_NUMERIC_STRING_CHECKER_MACROS_SVH
`define TYPED_NUMERIC_STRING_CHECKER_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define TNSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent in the next cycle
`define TNSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TNSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define TNSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/tnsc_pkg.sv =====
// ---------------------------------------------------------------------------
// tnsc_pkg
// Shared beat type and type codes for the typed numeric string checker.
// ---------------------------------------------------------------------------
package tnsc_pkg;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
        logic       empty_value;
        logic [3:0] value_type;
    } t_item;

    localparam logic [3:0] TYPE_STRING = 4'd0;
    localparam logic [3:0] TYPE_BOOL   = 4'd1;
    localparam logic [3:0] TYPE_I8     = 4'd2;
    localparam logic [3:0] TYPE_I16    = 4'd3;
    localparam logic [3:0] TYPE_I32    = 4'd4;
    localparam logic [3:0] TYPE_U8     = 4'd5;
    localparam logic [3:0] TYPE_U16    = 4'd6;
    localparam logic [3:0] TYPE_U32    = 4'd7;
    localparam logic [3:0] TYPE_F32    = 4'd8;
    localparam logic [3:0] TYPE_F64    = 4'd9;

    localparam int MAG_W = 33;

endpackage

// ===== rtl/tnsc_in_reg.sv =====
// ---------------------------------------------------------------------------
// tnsc_in_reg
// Input register: holds one beat until the checker core consumes it.
// ---------------------------------------------------------------------------
module tnsc_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  tnsc_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output tnsc_pkg::t_item o_item
);
    import tnsc_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  accept;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/tnsc_core.sv =====
// ---------------------------------------------------------------------------
// tnsc_core
// Per-value grammar state (integer, number, word matchers, accumulator) and
// the verdict for the beat that ends a value.
// ---------------------------------------------------------------------------
module tnsc_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  tnsc_pkg::t_item i_item,
    output logic           o_coercible
);
    import tnsc_pkg::*;

    typedef enum logic [2:0] {
        IP_START  = 3'd0,
        IP_MINUS  = 3'd1,
        IP_DIGITS = 3'd2,
        IP_ZERO   = 3'd3,
        IP_FAIL   = 3'd7
    } t_iphase;

    typedef enum logic [3:0] {
        NP_START = 4'd0,
        NP_MINUS = 4'd1,
        NP_ZERO  = 4'd2,
        NP_INT   = 4'd3,
        NP_DOT   = 4'd4,
        NP_FRAC  = 4'd5,
        NP_E     = 4'd6,
        NP_ESIGN = 4'd7,
        NP_EXP   = 4'd8,
        NP_FAIL  = 4'd15
    } t_nphase;

    localparam logic [MAG_W-1:0] LIM_P8  = 33'd127;
    localparam logic [MAG_W-1:0] LIM_N8  = 33'd128;
    localparam logic [MAG_W-1:0] LIM_P16 = 33'd32767;
    localparam logic [MAG_W-1:0] LIM_N16 = 33'd32768;
    localparam logic [MAG_W-1:0] LIM_P32 = 33'd2147483647;
    localparam logic [MAG_W-1:0] LIM_N32 = 33'd2147483648;
    localparam logic [MAG_W-1:0] LIM_U8  = 33'd255;
    localparam logic [MAG_W-1:0] LIM_U16 = 33'd65535;
    localparam logic [MAG_W-1:0] LIM_U32 = 33'd4294967295;

    function automatic logic [7:0] true_char(input logic [1:0] p);
        logic [7:0] c;
        case (p)
            2'd0:    c = "t";
            2'd1:    c = "r";
            2'd2:    c = "u";
            default: c = "e";
        endcase
        return c;
    endfunction

    function automatic logic [7:0] false_char(input logic [2:0] p);
        logic [7:0] c;
        case (p)
            3'd0:    c = "f";
            3'd1:    c = "a";
            3'd2:    c = "l";
            3'd3:    c = "s";
            default: c = "e";
        endcase
        return c;
    endfunction

    // state
    logic [3:0]       r_type,  n_type;
    logic             r_mid,   n_mid;
    t_nphase          r_np,    n_np;
    t_iphase          r_ip,    n_ip;
    logic             r_neg,   n_neg;
    logic [MAG_W-1:0] r_mag,   n_mag;
    logic             r_ovf,   n_ovf;
    logic [2:0]       r_wpos,  n_wpos;
    logic [1:0]       r_wflag, n_wflag;

    // stepped values, verdict inputs
    t_nphase          s_np;
    t_iphase          s_ip;
    logic             s_neg;
    logic [MAG_W-1:0] s_mag;
    logic             s_ovf;
    logic [2:0]       s_wpos;
    logic [1:0]       s_wflag;

    t_nphase          v_np;
    t_iphase          v_ip;
    logic             v_neg;
    logic [MAG_W-1:0] v_mag;
    logic             v_ovf;
    logic [2:0]       v_wpos;
    logic [1:0]       v_wflag;
    logic             v_empty;

    logic [3:0]       eff_type;
    logic [7:0]       c;
    logic             is_dig;
    logic             is_nz;
    logic             is_exp;
    logic             signed_t;
    logic [MAG_W+3:0] m_ext;
    logic [MAG_W+3:0] acc;
    logic [MAG_W-1:0] lim;
    logic             int_ok;
    logic             verdict;

    assign eff_type = r_mid ? r_type : i_item.value_type;
    assign c        = i_item.text_char;
    assign is_dig   = (c >= "0") && (c <= "9");
    assign is_nz    = (c >= "1") && (c <= "9");
    assign is_exp   = (c == "e") || (c == "E");
    assign signed_t = (eff_type == TYPE_I8) || (eff_type == TYPE_I16) ||
                      (eff_type == TYPE_I32);

    // magnitude * 10 + digit as shift-add
    assign m_ext = {4'd0, r_mag};
    assign acc   = (m_ext << 3) + (m_ext << 1) + {{(MAG_W){1'b0}}, c[3:0]};

    // one character of each grammar
    always_comb begin
        s_ip  = IP_FAIL;
        s_neg = r_neg;
        if (r_ip == IP_START && c == "-") begin
            if (signed_t) begin
                s_ip  = IP_MINUS;
                s_neg = 1'b1;
            end
        end else if (r_ip == IP_START || r_ip == IP_MINUS) begin
            if (c == "0") begin
                s_ip = IP_ZERO;
            end else if (is_nz) begin
                s_ip = IP_DIGITS;
            end
        end else if (r_ip == IP_DIGITS) begin
            if (is_dig) begin
                s_ip = IP_DIGITS;
            end
        end

        s_mag = r_mag;
        s_ovf = r_ovf;
        if ((s_ip == IP_DIGITS || s_ip == IP_ZERO) && !r_ovf) begin
            if (acc[MAG_W+3:MAG_W] != 4'd0) begin
                s_ovf = 1'b1;
            end else begin
                s_mag = acc[MAG_W-1:0];
            end
        end

        s_np = NP_FAIL;
        case (r_np)
            NP_START, NP_MINUS: begin
                if (r_np == NP_START && c == "-") begin
                    s_np = NP_MINUS;
                end else if (c == "0") begin
                    s_np = NP_ZERO;
                end else if (is_dig) begin
                    s_np = NP_INT;
                end
            end
            NP_ZERO: begin
                if (c == ".") begin
                    s_np = NP_DOT;
                end else if (is_exp) begin
                    s_np = NP_E;
                end
            end
            NP_INT: begin
                if (is_dig) begin
                    s_np = NP_INT;
                end else if (c == ".") begin
                    s_np = NP_DOT;
                end else if (is_exp) begin
                    s_np = NP_E;
                end
            end
            NP_DOT: begin
                if (is_dig) begin
                    s_np = NP_FRAC;
                end
            end
            NP_FRAC: begin
                if (is_dig) begin
                    s_np = NP_FRAC;
                end else if (is_exp) begin
                    s_np = NP_E;
                end
            end
            NP_E: begin
                if (c == "+" || c == "-") begin
                    s_np = NP_ESIGN;
                end else if (is_dig) begin
                    s_np = NP_EXP;
                end
            end
            NP_ESIGN, NP_EXP: begin
                if (is_dig) begin
                    s_np = NP_EXP;
                end
            end
            default: s_np = NP_FAIL;
        endcase

        s_wflag = r_wflag;
        if (!(r_wpos < 3'd4 && c == true_char(r_wpos[1:0]))) begin
            s_wflag[0] = 1'b0;
        end
        if (!(r_wpos < 3'd5 && c == false_char(r_wpos))) begin
            s_wflag[1] = 1'b0;
        end
        s_wpos = (r_wpos < 3'd7) ? r_wpos + 3'd1 : r_wpos;
    end

    // verdict works on the held state for an empty beat, stepped state otherwise
    always_comb begin
        if (i_item.empty_value) begin
            v_np    = r_np;
            v_ip    = r_ip;
            v_neg   = r_neg;
            v_mag   = r_mag;
            v_ovf   = r_ovf;
            v_wpos  = r_wpos;
            v_wflag = r_wflag;
            v_empty = !r_mid;
        end else begin
            v_np    = s_np;
            v_ip    = s_ip;
            v_neg   = s_neg;
            v_mag   = s_mag;
            v_ovf   = s_ovf;
            v_wpos  = s_wpos;
            v_wflag = s_wflag;
            v_empty = 1'b0;
        end

        case (eff_type)
            TYPE_I8:  lim = v_neg ? LIM_N8  : LIM_P8;
            TYPE_I16: lim = v_neg ? LIM_N16 : LIM_P16;
            TYPE_I32: lim = v_neg ? LIM_N32 : LIM_P32;
            TYPE_U8:  lim = LIM_U8;
            TYPE_U16: lim = LIM_U16;
            TYPE_U32: lim = LIM_U32;
            default:  lim = '0;
        endcase
        int_ok = (v_ip == IP_DIGITS || v_ip == IP_ZERO) && !v_ovf && (v_mag <= lim);

        verdict = 1'b0;
        case (eff_type)
            TYPE_STRING: verdict = 1'b1;
            TYPE_BOOL: verdict = !v_empty &&
                ((v_wflag[0] && v_wpos == 3'd4) || (v_wflag[1] && v_wpos == 3'd5));
            TYPE_I8, TYPE_I16, TYPE_I32,
            TYPE_U8, TYPE_U16, TYPE_U32: verdict = !v_empty && int_ok;
            TYPE_F32, TYPE_F64: verdict = !v_empty &&
                (v_np == NP_ZERO || v_np == NP_INT || v_np == NP_FRAC || v_np == NP_EXP);
            default: verdict = 1'b0;
        endcase
    end

    assign o_coercible = verdict;

    always_comb begin
        n_type  = r_type;
        n_mid   = r_mid;
        n_np    = r_np;
        n_ip    = r_ip;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_ovf   = r_ovf;
        n_wpos  = r_wpos;
        n_wflag = r_wflag;
        if (i_fire) begin
            n_type = eff_type;
            if (i_item.empty_value || i_item.last_char) begin
                n_mid   = 1'b0;
                n_np    = NP_START;
                n_ip    = IP_START;
                n_neg   = 1'b0;
                n_mag   = '0;
                n_ovf   = 1'b0;
                n_wpos  = 3'd0;
                n_wflag = 2'b11;
            end else begin
                n_mid   = 1'b1;
                n_np    = s_np;
                n_ip    = s_ip;
                n_neg   = s_neg;
                n_mag   = s_mag;
                n_ovf   = s_ovf;
                n_wpos  = s_wpos;
                n_wflag = s_wflag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type  <= TYPE_STRING;
            r_mid   <= 1'b0;
            r_np    <= NP_START;
            r_ip    <= IP_START;
            r_neg   <= 1'b0;
            r_mag   <= '0;
            r_ovf   <= 1'b0;
            r_wpos  <= 3'd0;
            r_wflag <= 2'b11;
        end else begin
            r_type  <= n_type;
            r_mid   <= n_mid;
            r_np    <= n_np;
            r_ip    <= n_ip;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
            r_ovf   <= n_ovf;
            r_wpos  <= n_wpos;
            r_wflag <= n_wflag;
        end
    end

endmodule

// ===== rtl/typed_numeric_string_checker.sv =====
// Path: an accepted ending beat is held in the input register, then its verdict is registered at the output.
// Throughput: one character beat per cycle while no ending beat waits on a stalled
//   output; the value state is updated as each beat is consumed (multiply-by-ten accumulate plus grammar step).
// Only ending beats stall behind an occupied, stalled output register.
// Reset: synchronous, active low; clears all value state and the valid flags, not the held beat or verdict.
// ---------------------------------------------------------------------------
// typed_numeric_string_checker
// Checks whether a streamed text value can be coerced to its target type.
// ---------------------------------------------------------------------------
`include "typed_numeric_string_checker_macros.svh"

module typed_numeric_string_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_text_char,
    input  logic       i_last_char,
    input  logic       i_empty_value,
    input  logic [3:0] i_value_type,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_coercible
);
    import tnsc_pkg::*;

    t_item in_item;
    t_item cur_item;
    logic  cur_valid;
    logic  cur_ends;
    logic  out_ready;
    logic  fire;
    logic  verdict;

    logic  r_out_valid, n_out_valid;
    logic  r_coercible;

    assign in_item.text_char   = i_text_char;
    assign in_item.last_char   = i_last_char;
    assign in_item.empty_value = i_empty_value;
    assign in_item.value_type  = i_value_type;

    tnsc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (in_item),
        .i_take  (fire),
        .o_valid (cur_valid),
        .o_item  (cur_item)
    );

    assign cur_ends  = cur_item.last_char || cur_item.empty_value;
    assign out_ready = !r_out_valid || !i_out_stall;
    // non-ending beats never wait on the output side
    assign fire      = cur_valid && (!cur_ends || out_ready);

    tnsc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (cur_item),
        .o_coercible (verdict)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (fire && cur_ends) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (fire && cur_ends) begin
            r_coercible <= verdict;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_coercible = r_coercible;

    `TNSC_ASSERT_NOW(a_end_waits, i_clk, i_rst_n, cur_valid && cur_ends && r_out_valid && i_out_stall, o_in_stall && !fire, "ending beat consumed while output blocked")
    `TNSC_ASSERT_NEXT(a_verdict_loaded, i_clk, i_rst_n, fire && cur_ends, o_out_valid, "verdict not presented after ending beat")
    `TNSC_ASSERT_NEXT(a_in_captured, i_clk, i_rst_n, i_in_valid && !o_in_stall, cur_valid, "accepted beat not held in input register")

endmodule

// ===== tb/sv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Streams typed text values into typed_numeric_string_checker one character
// beat at a time and checks each verdict against an in-bench grammar model.
// Directed values cover type bounds and grammar corners. A random mix then
// follows, with bursty input and a patterned output stall.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tnsc_pkg::*;

    localparam int          LIMIT_CYCLES     = 200000;
    localparam int          DRAIN_CYCLES     = 8;
    localparam int          RANDOM_BEATS     = 1200;
    localparam logic [3:0]  TYPE_UNKNOWN_MIN = 4'd10;
    localparam logic [3:0]  TYPE_CODE_MAX    = 4'd15;
    localparam logic [32:0] MAG_CEIL         = 33'h1_FFFF_FFFF;
    localparam logic [31:0] WORD_TRUE        = "true";
    localparam logic [39:0] WORD_FALSE       = "false";
    localparam logic [55:0] NUM_MARKS        = "-+.eEtf";

    typedef enum logic [2:0] {
        INT_IDLE   = 3'd0,
        INT_SIGN   = 3'd1,
        INT_DIGITS = 3'd2,
        INT_ZERO   = 3'd3,
        INT_BAD    = 3'd7
    } int_phase_e;

    typedef enum logic [3:0] {
        NUM_IDLE       = 4'd0,
        NUM_SIGN       = 4'd1,
        NUM_ZERO       = 4'd2,
        NUM_WHOLE      = 4'd3,
        NUM_POINT      = 4'd4,
        NUM_FRAC       = 4'd5,
        NUM_EXP_MARK   = 4'd6,
        NUM_EXP_SIGN   = 4'd7,
        NUM_EXP_DIGITS = 4'd8,
        NUM_BAD        = 4'd15
    } num_phase_e;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_e;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_text_char   = 8'h00;
    logic       i_last_char   = 1'b0;
    logic       i_empty_value = 1'b0;
    logic [3:0] i_value_type  = TYPE_STRING;
    logic       o_out_valid;
    logic       i_out_stall   = 1'b0;
    logic       o_coercible;

    // value state mirrored from the block
    logic [3:0]  m_type;
    logic        m_mid;
    int_phase_e  m_int;
    num_phase_e  m_num;
    logic        m_neg;
    logic [32:0] m_mag;
    logic        m_ovf;
    logic [2:0]  m_word_pos;
    logic [1:0]  m_word_ok;

    bit          verdict_q[$];
    logic [7:0]  txt[$];
    int          n_errors    = 0;
    int          cycle_count = 0;
    int          beats_sent  = 0;
    int          burst_left  = 0;
    stall_mode_e stall_mode  = STALL_NONE;
    int          stall_left  = 0;

    typed_numeric_string_checker u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_text_char   (i_text_char),
        .i_last_char   (i_last_char),
        .i_empty_value (i_empty_value),
        .i_value_type  (i_value_type),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_coercible   (o_coercible)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------- random helpers ----------------

    function automatic logic [7:0] rand_byte(input int unsigned lo, input int unsigned hi);
        int unsigned u;
        u = $urandom_range(hi, lo);
        return u[7:0];
    endfunction

    function automatic logic [3:0] rand_code(input int unsigned lo, input int unsigned hi);
        int unsigned u;
        u = $urandom_range(hi, lo);
        return u[3:0];
    endfunction

    function automatic bit coin();
        return $urandom_range(0, 1) == 1;
    endfunction

    // digits and number marks half the time, else any byte or a control character
    function automatic logic [7:0] noise_char();
        int unsigned idx;
        case ($urandom_range(0, 3))
            0: return rand_byte(0, 255);
            1: return rand_byte("0", "9");
            2: begin
                idx = $urandom_range(0, 6);
                return NUM_MARKS[8*idx +: 8];
            end
            default: return rand_byte(0, 31);
        endcase
    endfunction

    // ---------------- model ----------------

    function automatic void clear_value();
        m_mid      = 1'b0;
        m_int      = INT_IDLE;
        m_num      = NUM_IDLE;
        m_neg      = 1'b0;
        m_mag      = '0;
        m_ovf      = 1'b0;
        m_word_pos = '0;
        m_word_ok  = 2'b11;
    endfunction

    function automatic logic [32:0] range_limit(input logic [3:0] t, input logic neg);
        case (t)
            TYPE_I8:  return neg ? 33'd128        : 33'd127;
            TYPE_I16: return neg ? 33'd32768      : 33'd32767;
            TYPE_I32: return neg ? 33'd2147483648 : 33'd2147483647;
            TYPE_U8:  return neg ? 33'd0          : 33'd255;
            TYPE_U16: return neg ? 33'd0          : 33'd65535;
            TYPE_U32: return neg ? 33'd0          : 33'd4294967295;
            default:  return 33'd0;
        endcase
    endfunction

    function automatic bit judge(input bit no_chars);
        if (m_type == TYPE_STRING) return 1'b1;
        if (no_chars) return 1'b0;
        case (m_type)
            TYPE_BOOL:
                return (m_word_ok[0] && m_word_pos == 3'd4) ||
                       (m_word_ok[1] && m_word_pos == 3'd5);
            TYPE_I8, TYPE_I16, TYPE_I32, TYPE_U8, TYPE_U16, TYPE_U32: begin
                if (m_int != INT_DIGITS && m_int != INT_ZERO) return 1'b0;
                if (m_ovf) return 1'b0;
                return m_mag <= range_limit(m_type, m_neg);
            end
            TYPE_F32, TYPE_F64:
                return m_num == NUM_ZERO || m_num == NUM_WHOLE ||
                       m_num == NUM_FRAC || m_num == NUM_EXP_DIGITS;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void absorb_beat(input logic [7:0] c, input logic last,
                                        input logic empty, input logic [3:0] vt);
        bit          first;
        bit          dig;
        bit          is_e;
        int_phase_e  ip;
        num_phase_e  np;
        logic [36:0] acc;
        int          pos;
        first = !m_mid;
        if (first) m_type = vt;
        if (empty) begin
            verdict_q.push_back(judge(first));
            clear_value();
            return;
        end
        dig  = (c >= "0" && c <= "9");
        is_e = (c == "e" || c == "E");

        // integer grammar plus magnitude accumulate
        ip = INT_BAD;
        if (m_int == INT_IDLE && c == "-") begin
            if (m_type == TYPE_I8 || m_type == TYPE_I16 || m_type == TYPE_I32) begin
                ip    = INT_SIGN;
                m_neg = 1'b1;
            end
        end else if (m_int == INT_IDLE || m_int == INT_SIGN) begin
            if (c == "0") ip = INT_ZERO;
            else if (dig) ip = INT_DIGITS;
        end else if (m_int == INT_DIGITS) begin
            if (dig) ip = INT_DIGITS;
        end
        if ((ip == INT_DIGITS || ip == INT_ZERO) && !m_ovf) begin
            acc = {4'd0, m_mag} * 37'd10 + {29'd0, c - "0"};
            if (acc > {4'd0, MAG_CEIL}) m_ovf = 1'b1;
            else m_mag = acc[32:0];
        end
        m_int = ip;

        // number grammar
        np = NUM_BAD;
        case (m_num)
            NUM_IDLE, NUM_SIGN: begin
                if (m_num == NUM_IDLE && c == "-") np = NUM_SIGN;
                else if (c == "0") np = NUM_ZERO;
                else if (dig) np = NUM_WHOLE;
            end
            NUM_ZERO: begin
                if (c == ".") np = NUM_POINT;
                else if (is_e) np = NUM_EXP_MARK;
            end
            NUM_WHOLE: begin
                if (dig) np = NUM_WHOLE;
                else if (c == ".") np = NUM_POINT;
                else if (is_e) np = NUM_EXP_MARK;
            end
            NUM_POINT: if (dig) np = NUM_FRAC;
            NUM_FRAC: begin
                if (dig) np = NUM_FRAC;
                else if (is_e) np = NUM_EXP_MARK;
            end
            NUM_EXP_MARK: begin
                if (c == "+" || c == "-") np = NUM_EXP_SIGN;
                else if (dig) np = NUM_EXP_DIGITS;
            end
            NUM_EXP_SIGN, NUM_EXP_DIGITS: if (dig) np = NUM_EXP_DIGITS;
            default: ;
        endcase
        m_num = np;

        // word match, position saturates at 7
        pos = m_word_pos;
        if (pos >= 4) m_word_ok[0] = 1'b0;
        else if (c != WORD_TRUE[8*(3 - pos) +: 8]) m_word_ok[0] = 1'b0;
        if (pos >= 5) m_word_ok[1] = 1'b0;
        else if (c != WORD_FALSE[8*(4 - pos) +: 8]) m_word_ok[1] = 1'b0;
        if (pos != 7) m_word_pos = m_word_pos + 3'd1;

        m_mid = 1'b1;
        if (last) begin
            verdict_q.push_back(judge(1'b0));
            clear_value();
        end
    endfunction

    // ---------------- output side ----------------

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_left <= $urandom_range(16, 96);
            case ($urandom_range(0, 3))
                0: stall_mode <= STALL_NONE;
                1: stall_mode <= STALL_COIN;
                2: stall_mode <= STALL_HEAVY;
                default: stall_mode <= STALL_PERIODIC;
            endcase
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_COIN:  i_out_stall <= coin();
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 7) != 0);
            default:     i_out_stall <= ((cycle_count % 5) < 2);
        endcase
    end

    always @(posedge i_clk) begin : verdict_check
        bit want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                $error("coercible beat with no verdict pending: actual %0b", o_coercible);
                n_errors++;
            end else begin
                want = verdict_q.pop_front();
                if (o_coercible !== want) begin
                    $error("coercible mismatch: expected %0b, actual %0b", want, o_coercible);
                    n_errors++;
                end
            end
        end
    end

    // ---------------- input side ----------------

    task automatic send_beat(input logic [7:0] ch, input logic last,
                             input logic empty, input logic [3:0] vt);
        int gap;
        i_in_valid    <= 1'b1;
        i_text_char   <= ch;
        i_last_char   <= last;
        i_empty_value <= empty;
        i_value_type  <= vt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        absorb_beat(ch, last, empty, vt);
        beats_sent++;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // type is only sampled on the first beat, so later beats carry junk there
    task automatic send_value(input logic [3:0] vt, input bit flag_close);
        int n;
        n = txt.size();
        for (int k = 0; k < n; k++)
            send_beat(txt[k], (k == n - 1) && !flag_close, 1'b0,
                      (k == 0) ? vt : rand_code(0, TYPE_CODE_MAX));
        if (n == 0 || flag_close)
            send_beat(rand_byte(0, 255), coin(), 1'b1,
                      (n == 0) ? vt : rand_code(0, TYPE_CODE_MAX));
    endtask

    task automatic load_text(input string s);
        txt.delete();
        for (int k = 0; k < s.len(); k++) txt.push_back(s[k]);
    endtask

    task automatic send_text(input logic [3:0] vt, input string s);
        load_text(s);
        send_value(vt, 1'b0);
    endtask

    // ---------------- generators ----------------

    task automatic gen_integer(input logic [3:0] t);
        logic [63:0] mag;
        logic [63:0] d;
        bit          neg;
        neg = (t <= TYPE_I32) ? coin() : ($urandom_range(0, 9) == 0);
        mag = {31'd0, range_limit(t, neg)};
        txt.delete();
        case ($urandom_range(0, 6))
            0: ;
            1: mag = mag + 64'd1;
            2: if (mag != 64'd0) mag = mag - 64'd1;
            3: mag = {32'd0, $urandom_range(0, 99)};
            4: mag = {32'd0, $urandom};
            5: mag = {32'd0, $urandom} + 64'h1_0000_0000;
            default: begin
                // ten to thirteen digits, which can run past the accumulator
                txt.push_back(rand_byte("1", "9"));
                repeat ($urandom_range(9, 12)) txt.push_back(rand_byte("0", "9"));
            end
        endcase
        if (txt.size() == 0) begin
            if (mag == 64'd0) txt.push_back("0");
            while (mag != 64'd0) begin
                d = mag % 64'd10;
                txt.push_front("0" + d[7:0]);
                mag = mag / 64'd10;
            end
        end
        if ($urandom_range(0, 9) == 0) txt.push_front("0");
        if ($urandom_range(0, 9) == 0) txt[$urandom_range(0, txt.size() - 1)] = noise_char();
        if (neg) txt.push_front("-");
    endtask

    task automatic gen_float();
        txt.delete();
        if (coin()) txt.push_back("-");
        if ($urandom_range(0, 2) == 0) begin
            txt.push_back("0");
        end else begin
            txt.push_back(rand_byte("1", "9"));
            repeat ($urandom_range(0, 4)) txt.push_back(rand_byte("0", "9"));
        end
        if (coin()) begin
            txt.push_back(".");
            repeat ($urandom_range(0, 4)) txt.push_back(rand_byte("0", "9"));
        end
        if (coin()) begin
            txt.push_back(coin() ? "e" : "E");
            case ($urandom_range(0, 2))
                0: txt.push_back("+");
                1: txt.push_back("-");
                default: ;
            endcase
            repeat ($urandom_range(0, 3)) txt.push_back(rand_byte("0", "9"));
        end
        if ($urandom_range(0, 5) == 0) txt[$urandom_range(0, txt.size() - 1)] = noise_char();
    endtask

    task automatic gen_word();
        if (coin()) load_text("true");
        else load_text("false");
        case ($urandom_range(0, 5))
            0: txt.delete(txt.size() - 1);
            1: txt.push_back(noise_char());
            2: txt[$urandom_range(0, txt.size() - 1)] = noise_char();
            3: txt[0] = (txt[0] == "t") ? "T" : "F";
            default: ;
        endcase
    endtask

    task automatic gen_noise();
        txt.delete();
        repeat ($urandom_range(0, 8)) txt.push_back(noise_char());
    endtask

    // ---------------- tests ----------------

    task automatic test_empty_values();
        send_text(TYPE_STRING, "");
        send_text(TYPE_BOOL, "");
        send_text(TYPE_U32, "");
        send_text(TYPE_F64, "");
        send_text(TYPE_CODE_MAX, "");
    endtask

    task automatic test_bool_words();
        send_text(TYPE_BOOL, "true");
        send_text(TYPE_BOOL, "false");
        send_text(TYPE_BOOL, "tru");
        send_text(TYPE_BOOL, "falsey");
        send_text(TYPE_BOOL, "True");
        send_text(TYPE_STRING, "true");
    endtask

    task automatic test_integer_bounds();
        send_text(TYPE_I8, "-128");
        send_text(TYPE_I8, "128");
        send_text(TYPE_I8, "-0");
        send_text(TYPE_U8, "255");
        send_text(TYPE_U8, "-1");
        send_text(TYPE_U8, "01");
        send_text(TYPE_I16, "-32768");
        send_text(TYPE_U16, "65535");
        send_text(TYPE_I32, "2147483647");
        send_text(TYPE_I32, "-2147483649");
        send_text(TYPE_U32, "4294967295");
        send_text(TYPE_U32, "4294967296");
        send_text(TYPE_U32, "8589934591");
        send_text(TYPE_U32, "8589934592");
        send_text(TYPE_I32, "-99999999999");
    endtask

    task automatic test_float_grammar();
        send_text(TYPE_F32, "-0.5e+10");
        send_text(TYPE_F64, "1E-3");
        send_text(TYPE_F32, "1.");
        send_text(TYPE_F64, ".5");
        send_text(TYPE_F32, "01");
        send_text(TYPE_F64, "0e");
        send_text(TYPE_F32, "-");
        send_text(TYPE_F64, "12.5E7");
    endtask

    task automatic test_odd_endings();
        // empty flag in mid value closes on what came before
        load_text("12");
        send_value(TYPE_U8, 1'b1);
        load_text("-");
        send_value(TYPE_I16, 1'b1);
        // both flags on the first beat: empty wins
        send_beat("7", 1'b1, 1'b1, TYPE_I8);
        // top-bit and control characters
        load_text("1");
        txt.push_back(8'hFF);
        send_value(TYPE_STRING, 1'b0);
        load_text("1");
        txt.push_back(8'h80);
        send_value(TYPE_F32, 1'b0);
        load_text("4");
        txt.push_back(8'h00);
        send_value(TYPE_U16, 1'b0);
        send_text(TYPE_UNKNOWN_MIN, "5");
        send_text(TYPE_CODE_MAX, "5");
    endtask

    task automatic test_random_mix();
        int         stop_at;
        logic [3:0] t;
        int unsigned pick;
        stop_at = beats_sent + RANDOM_BEATS;
        while (beats_sent < stop_at) begin
            pick = $urandom_range(0, 19);
            if (pick < 10) t = pick[3:0];
            else if (pick < 18) t = rand_code(TYPE_I8, TYPE_F64);
            else t = rand_code(TYPE_UNKNOWN_MIN, TYPE_CODE_MAX);
            if ($urandom_range(0, 9) < 2) begin
                gen_noise();
            end else begin
                case (t)
                    TYPE_STRING: gen_noise();
                    TYPE_BOOL:   gen_word();
                    TYPE_I8, TYPE_I16, TYPE_I32, TYPE_U8, TYPE_U16, TYPE_U32:
                        gen_integer(t);
                    default:     gen_float();
                endcase
            end
            send_value(t, $urandom_range(0, 9) == 0);
        end
    endtask

    initial begin
        m_type = TYPE_STRING;
        clear_value();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_values();
        test_bool_words();
        test_integer_bounds();
        test_float_grammar();
        test_odd_endings();
        test_random_mix();

        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
